[rtl/prc_pkg.sv]
// ----------------------------------------------------------------------------
// prc_pkg: shared types for the prime range counter
// Fixed field widths and the status bundle of the remainder unit.
// ----------------------------------------------------------------------------
package prc_pkg;

   // Width of the range bounds and of the count on the ports
   localparam int unsigned FIELD_WIDTH = 16;

   // Status returned by the remainder unit to the sequencer
   typedef struct packed {
      logic done;   // remainder is final this cycle
      logic zero;   // final remainder is zero
   } rem_status_type;

endpackage

[rtl/prc_rem_unit.sv]
// ----------------------------------------------------------------------------
// prc_rem_unit: bit-serial remainder unit
// Restoring shift-subtract remainder of dividend by divisor, one dividend
// bit per cycle, most significant bit first. Operands are held by the caller.
// ----------------------------------------------------------------------------
module prc_rem_unit #(
   parameter int unsigned CW = 16,
   parameter int unsigned DW = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [CW-1:0]          dividend,
   input  logic [DW-1:0]          divisor,
   output prc_pkg::rem_status_type status
);

   localparam int unsigned IW = (CW > 1) ? $clog2(CW) : 1;

   logic [DW:0]   rem_ff,  rem_in;
   logic [IW-1:0] idx_ff,  idx_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   shifted;
   logic [DW:0]   div_ext;

   assign div_ext = {1'b0, divisor};
   assign shifted = {rem_ff[DW-1:0], dividend[idx_ff]};

   // one shift-subtract step per cycle
   always_comb begin
      rem_in  = rem_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         idx_in  = IW'(CW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = (shifted >= div_ext) ? (shifted - div_ext) : shifted;
         if (idx_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      idx_ff <= idx_in;
   end

   assign status.done = done_ff;
   assign status.zero = (rem_ff == '0);

   // partial remainder stays below the divisor while stepping
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |-> rem_ff < div_ext)
      else $error("partial remainder reached divisor");

   // done follows exactly the last step
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start && idx_ff == '0 |=> done_ff && !busy_ff)
      else $error("remainder unit did not finish after last bit");

endmodule

[rtl/prime_range_counter_top.sv]
// ----------------------------------------------------------------------------
// prime_range_counter_top: counts primes in [range_low, range_high)
// Each value is tested by trial division, divisors from 2 while d*d <= value;
// each trial uses a shared bit-serial remainder unit.
//
//   channel | direction | ports                          | handshake
//   req     | in        | req_range_low, req_range_high  | req_valid / req_stall
//   rsp     | out       | rsp_prime_count                | rsp_valid / rsp_stall
//
// After acceptance the sequencer takes each value through CHECK, then for values
// of 2 and up through TEST and DIV for each trial divisor, and DONE moves the
// count to the output register; each trial runs the remainder unit over
// W = min(VALUE_WIDTH,16) dividend bits, one bit per cycle.
// req_stall is high while a word is in work; the next word is accepted while
// a finished count waits in the output register.
// Reset is synchronous and clears the sequencer and the valid flag.
// ----------------------------------------------------------------------------
module prime_range_counter_top #(
   parameter int unsigned VALUE_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [prc_pkg::FIELD_WIDTH-1:0]   req_range_low,
   input  logic [prc_pkg::FIELD_WIDTH-1:0]   req_range_high,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [prc_pkg::FIELD_WIDTH-1:0]   rsp_prime_count
);

   // tested width and trial divisor width
   localparam int unsigned CW = (VALUE_WIDTH < prc_pkg::FIELD_WIDTH) ?
                                VALUE_WIDTH : prc_pkg::FIELD_WIDTH;
   localparam int unsigned DW = (CW + 1) / 2 + 1;
   localparam int unsigned SW = 2 * DW;
   localparam int unsigned NW = prc_pkg::FIELD_WIDTH;

   // sequencer codes
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_TEST  = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cand_ff,  cand_in;
   logic [CW-1:0] high_ff,  high_in;
   logic [DW-1:0] div_ff,   div_in;
   logic [SW-1:0] sq_ff,    sq_in;
   logic [NW-1:0] count_ff, count_in;
   logic [NW-1:0] out_ff,   out_in;
   logic          out_vld_ff, out_vld_in;
   logic          rem_start;
   logic          req_take;
   logic          rsp_take;
   prc_pkg::rem_status_type rem_status;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = out_vld_ff && !rsp_stall;

   // shared remainder unit
   prc_rem_unit #(
      .CW (CW),
      .DW (DW)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (cand_ff),
      .divisor  (div_ff),
      .status   (rem_status)
   );

   // sequencer: walk the range, trial-divide each candidate
   always_comb begin
      state_in   = state_ff;
      cand_in    = cand_ff;
      high_in    = high_ff;
      div_in     = div_ff;
      sq_in      = sq_ff;
      count_in   = count_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_take;
      rem_start  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cand_in  = req_range_low[CW-1:0];
               high_in  = req_range_high[CW-1:0];
               count_in = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cand_ff >= high_ff) begin
               state_in = ST_DONE;
            end else if (cand_ff < CW'(2)) begin
               cand_in = cand_ff + 1'b1;
            end else begin
               div_in   = DW'(2);
               sq_in    = SW'(4);
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (sq_ff > SW'(cand_ff)) begin
               count_in = count_ff + 1'b1;
               cand_in  = cand_ff + 1'b1;
               state_in = ST_CHECK;
            end else begin
               rem_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_status.done) begin
               if (rem_status.zero) begin
                  cand_in  = cand_ff + 1'b1;
                  state_in = ST_CHECK;
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1
                  sq_in    = sq_ff + SW'({div_ff, 1'b1});
                  div_in   = div_ff + 1'b1;
                  state_in = ST_TEST;
               end
            end
         end
         ST_DONE: begin
            if (!out_vld_ff || rsp_take) begin
               out_in     = count_ff;
               out_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
      end
      cand_ff  <= cand_in;
      high_ff  <= high_in;
      div_ff   <= div_in;
      sq_ff    <= sq_in;
      count_ff <= count_in;
      out_ff   <= out_in;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_prime_count = out_ff;

   // running square tracks the divisor
   a_square: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TEST |-> sq_ff == SW'(div_ff) * SW'(div_ff))
      else $error("running square out of step with divisor");

   // trial divisors start at two
   a_div_min: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TEST || state_ff == ST_DIV |-> div_ff >= DW'(2))
      else $error("trial divisor below two");

   // an accepted word starts the range walk
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_CHECK)
      else $error("accepted word did not start the walk");

   // a divisor under test never exceeds the candidate's root
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> sq_ff <= SW'(cand_ff))
      else $error("division started past the square root");

endmodule

[verif/prime_range_counter_top_tb.sv]
// ----------------------------------------------------------------------------
// prime_range_counter_top_tb: self-checking bench for the prime range counter
// Sends range words [low, high) through the req channel in random bursts and
// checks every count on the rsp channel against a trial-division predictor.
// Directed words cover empty, reversed and boundary ranges; random words are
// mostly narrow so the bit-serial divider keeps the run short.
// ----------------------------------------------------------------------------
module prime_range_counter_top_tb;

   localparam int unsigned VALUE_W     = 16;
   localparam int unsigned RANDOM_WORDS = 77;
   localparam int unsigned IDLE_LIMIT  = 400000;
   localparam int unsigned TAIL_CYCLES = 40;

   typedef logic [prc_pkg::FIELD_WIDTH-1:0] field_type;

   typedef struct {
      field_type low;
      field_type high;
   } range_word_type;

   logic      clock          = 1'b0;
   logic      reset          = 1'b1;
   logic      req_valid      = 1'b0;
   logic      req_stall;
   field_type req_range_low  = '0;
   field_type req_range_high = '0;
   logic      rsp_valid;
   logic      rsp_stall      = 1'b0;
   field_type rsp_prime_count;

   range_word_type pending_words[$];
   field_type      counts_due[$];
   int             error_count = 0;
   int             burst_left  = 1;
   int             gap_left    = 0;
   int unsigned    stall_phase = 0;
   int unsigned    idle_cycles = 0;

   prime_range_counter_top #(
      .VALUE_WIDTH(VALUE_W)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_prime_count(rsp_prime_count)
   );

   always #1 clock = ~clock;

   // Trial division over [lo, hi); values below 2 are not prime
   function automatic field_type primes_in_range(input field_type lo, input field_type hi);
      field_type   tally;
      int unsigned val;
      int unsigned div;
      bit          val_prime;
      tally = '0;
      for (val = lo; val < hi; val++) begin
         val_prime = (val >= 2);
         for (div = 2; val_prime && div * div <= val; div++) begin
            if (val % div == 0) val_prime = 1'b0;
         end
         if (val_prime) tally++;
      end
      return tally;
   endfunction

   task automatic report_mismatch(input string what, input field_type got,
                                  input field_type want);
      $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic add_range(input field_type lo, input field_type hi);
      range_word_type w;
      w.low  = lo;
      w.high = hi;
      pending_words.push_back(w);
   endtask

   // Driver: bursts of words separated by random gaps
   always @(posedge clock) begin : driver
      range_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         // a word went through at this edge: log its count
         if (req_valid) counts_due.push_back(primes_in_range(req_range_low, req_range_high));
         if (gap_left > 0 || pending_words.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_valid <= 1'b0;
         end else begin
            w = pending_words.pop_front();
            req_valid      <= 1'b1;
            req_range_low  <= w.low;
            req_range_high <= w.high;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 8);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
         end
      end
   end

   // Receiver stall pattern: clear, random, then periodic, phase picked by stall_phase >> 7
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         case ((stall_phase >> 7) % 3)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 2) == 0);
            end
            default: begin
               rsp_stall <= ((stall_phase % 16) < 5);
            end
         endcase
      end
   end

   // Monitor: compare each count with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (counts_due.size() == 0) begin
            report_mismatch("unexpected prime_count", rsp_prime_count, '0);
         end else if (rsp_prime_count !== counts_due[0]) begin
            report_mismatch("prime_count", rsp_prime_count, counts_due.pop_front());
         end else begin
            void'(counts_due.pop_front());
         end
      end
   end

   // Watchdog: too long without any word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("prime_range_counter_top regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned lo;
      int unsigned span;
      int unsigned pick;

      // Empty and reversed ranges
      add_range(16'd0, 16'd0);
      add_range(16'hFFFF, 16'hFFFF);
      add_range(16'hFFFF, 16'd0);
      add_range(16'd100, 16'd50);
      // Values below 2 and the smallest primes and composites
      add_range(16'd0, 16'd1);
      add_range(16'd0, 16'd2);
      add_range(16'd0, 16'd3);
      add_range(16'd1, 16'd2);
      add_range(16'd2, 16'd3);
      add_range(16'd3, 16'd4);
      add_range(16'd4, 16'd5);
      add_range(16'd0, 16'd100);
      // Squares of primes (and 255 squared): for a prime square the last trial has divisor squared equal to the value
      add_range(16'd49, 16'd50);
      add_range(16'd121, 16'd122);
      add_range(16'd63001, 16'd63002);
      add_range(16'd65025, 16'd65026);
      // Top of the value range, largest 16-bit primes
      add_range(16'd65519, 16'd65520);
      add_range(16'd65520, 16'hFFFF);
      add_range(16'hFFFE, 16'hFFFF);
      // Bit patterns and a wider mid range
      add_range(16'h7FFF, 16'h8001);
      add_range(16'h5555, 16'h5560);
      add_range(16'hAAAA, 16'hAAB0);
      add_range(16'd1000, 16'd1200);

      // Random words: mostly narrow windows anywhere, some wide low ranges
      repeat (RANDOM_WORDS) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            lo   = $urandom_range(0, 16'hFFFF);
            span = $urandom_range(0, 12);
            add_range(field_type'(lo),
                      field_type'((lo + span > 16'hFFFF) ? 16'hFFFF : lo + span));
         end else if (pick == 7) begin
            lo   = $urandom_range(0, 2047);
            span = $urandom_range(13, 200);
            add_range(field_type'(lo), field_type'(lo + span));
         end else if (pick == 8) begin
            lo = $urandom_range(0, 16'hFFFF);
            add_range(field_type'(lo), field_type'($urandom_range(0, lo)));
         end else begin
            lo = $urandom_range(0, 16'hFFFF);
            add_range(field_type'(lo), field_type'(lo));
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Drain: every word sent and every count returned
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || counts_due.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("prime_range_counter_top regression: pass");
      end else begin
         $display("prime_range_counter_top regression: fail");
      end
      $finish;
   end

endmodule
